@@ hw/rtl/edza_pkg.sv @@
// ----------------------------------------------------------------------------
// edza_pkg
// shared types, constants and codes of the edge zone color averager
// ----------------------------------------------------------------------------
package edza_pkg;

    localparam int MAX_FRAME_DIM   = 4096;
    localparam int MAX_LEDS_ACROSS = 64;
    localparam int MAX_LEDS_DOWN   = 32;
    localparam int RING_SIZE       = 2 * MAX_LEDS_ACROSS + 2 * MAX_LEDS_DOWN;

    localparam int DIM_W    = 13;
    localparam int CNT_W    = 12;
    localparam int ACROSS_W = 7;
    localparam int DOWN_W   = 6;
    localparam int SUM_W    = 32;
    localparam int DIVS_W   = 24;
    localparam int COLOR_W  = 24;
    localparam int LED_AW   = 8;
    localparam int BAND_AW  = $clog2(MAX_LEDS_ACROSS);
    localparam int SIDE_AW  = $clog2(MAX_LEDS_DOWN);
    localparam int PADDR_W  = 5;
    localparam int PDATA_W  = 32;

    // register indexes
    localparam logic [2:0] REG_FRAME_WIDTH  = 3'd0;
    localparam logic [2:0] REG_FRAME_HEIGHT = 3'd1;
    localparam logic [2:0] REG_LEDS_ACROSS  = 3'd2;
    localparam logic [2:0] REG_LEDS_DOWN    = 3'd3;
    localparam logic [2:0] REG_BOTTOM_EN    = 3'd4;
    localparam logic [2:0] REG_BAR_DETECT   = 3'd5;

    // geometry divisions in order
    localparam logic [2:0] GS_SIDE_W  = 3'd0;
    localparam logic [2:0] GS_SIDE_H  = 3'd1;
    localparam logic [2:0] GS_BAND_W  = 3'd2;
    localparam logic [2:0] GS_BAND_H  = 3'd3;
    localparam logic [2:0] GS_BAND_H2 = 3'd4;

    typedef logic [2:0][SUM_W-1:0] rgb_sum_t;

    typedef struct packed {
        rgb_sum_t tp;
        rgb_sum_t ts;
        rgb_sum_t bp;
        rgb_sum_t bs;
    } band_entry_t;

    typedef struct packed {
        rgb_sum_t left;
        rgb_sum_t right;
    } side_entry_t;

    typedef struct packed {
        logic               en;
        logic [LED_AW-1:0]  addr;
        logic [COLOR_W-1:0] data;
    } led_wr_t;

    typedef enum logic [3:0] {
        ST_GEOM_DIV,
        ST_GEOM_WAIT,
        ST_GEOM_MUL,
        ST_CLEAR,
        ST_IDLE,
        ST_PIX_WR,
        ST_READ,
        ST_FIN_START,
        ST_FIN_RD,
        ST_FIN_LATCH,
        ST_FIN_DIV,
        ST_FIN_WAIT,
        ST_FIN_WR_A,
        ST_FIN_WR_B
    } state_t;

endpackage

@@ hw/rtl/edza_div.sv @@
// ----------------------------------------------------------------------------
// edza_div
// restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module edza_div (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [edza_pkg::SUM_W-1:0]   dividend,
    input  logic [edza_pkg::DIVS_W-1:0]  divisor,
    output logic                         done,
    output logic [edza_pkg::SUM_W-1:0]   quotient
);
    import edza_pkg::*;

    localparam int STEP_W = $clog2(SUM_W);

    logic              busy_reg;
    logic              done_reg;
    logic [STEP_W-1:0] step_reg;
    logic [DIVS_W-1:0] den_reg;
    logic [DIVS_W-1:0] rem_reg;
    logic [SUM_W-1:0]  quo_reg;
    logic [DIVS_W:0]   rem_sh;
    logic              fits;

    assign rem_sh = {rem_reg, quo_reg[SUM_W-1]};
    assign fits   = rem_sh >= {1'b0, den_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                step_reg <= '1;
            end
            else if (busy_reg)
            begin
                step_reg <= step_reg - STEP_W'(1);
                if (step_reg == '0)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= divisor;
            rem_reg <= '0;
            quo_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= fits ? DIVS_W'(rem_sh - {1'b0, den_reg}) : rem_sh[DIVS_W-1:0];
            quo_reg <= {quo_reg[SUM_W-2:0], fits};
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

@@ hw/rtl/edza_led.sv @@
// ----------------------------------------------------------------------------
// edza_led
// led color store with valid bits, one write and one registered read port
// ----------------------------------------------------------------------------
module edza_led (
    input  logic                          clk,
    input  logic                          rst_n,
    input  edza_pkg::led_wr_t             wr,
    input  logic                          rd_en,
    input  logic [edza_pkg::LED_AW-1:0]   rd_addr,
    output logic [edza_pkg::COLOR_W-1:0]  rd_data
);
    import edza_pkg::*;

    logic [COLOR_W-1:0] mem [RING_SIZE];
    logic [RING_SIZE-1:0] valid_reg;
    logic [COLOR_W-1:0] data_reg;
    logic               hit_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            if (wr.en && (32'(wr.addr) < RING_SIZE))
                valid_reg[wr.addr] <= 1'b1;
            if (rd_en)
                hit_reg <= (32'(rd_addr) < RING_SIZE) && valid_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr.en && (32'(wr.addr) < RING_SIZE))
            mem[wr.addr] <= wr.data;
        if (rd_en && (32'(rd_addr) < RING_SIZE))
            data_reg <= mem[rd_addr];
    end

    // entries never written read as zero
    assign rd_data = hit_reg ? data_reg : '0;

endmodule

@@ hw/rtl/edge_zone_color_averager.sv @@
// ----------------------------------------------------------------------------
// edge_zone_color_averager
// per-zone edge color averaging of a raster pixel stream for an led ring
// ----------------------------------------------------------------------------
// input channel: in_valid/in_stall with operation, red, green, blue, led_index.
// a pixel transaction is a read-modify-write of the zone sum memories (one
// read port each) and returns nothing. a read transaction returns led_color
// on the out_valid/out_stall channel via the led store and output registers.
// after the last pixel of a frame the block produces 6 means per led pair in
// the shared divider, first for the D side pairs, then for the A band pairs
// (D, A = leds down/across); in_stall stays high.
// reset and every register write recompute the geometry (5 divisions) and
// then clear the band and side sum memories (64 and 32 entries), during which
// no transaction is accepted. the led store reads zero after reset.
// a result waits in the output register while the receiver stalls; pixels are
// still taken, a further read waits until the result has gone.
// registers sit on the apb port at 4*index.
// ----------------------------------------------------------------------------
module edge_zone_color_averager (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          operation,
    input  logic [7:0]                    red,
    input  logic [7:0]                    green,
    input  logic [7:0]                    blue,
    input  logic [edza_pkg::LED_AW-1:0]   led_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [edza_pkg::COLOR_W-1:0]  led_color,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [edza_pkg::PADDR_W-1:0]  paddr,
    input  logic [edza_pkg::PDATA_W-1:0]  pwdata,
    output logic [edza_pkg::PDATA_W-1:0]  prdata,
    output logic                          pready
);
    import edza_pkg::*;

    // configuration
    logic [DIM_W-1:0]    fw_reg, fh_reg;
    logic [ACROSS_W-1:0] la_reg;
    logic [DOWN_W-1:0]   ld_reg;
    logic                be_reg, bd_reg;
    logic                cfg_hit;
    logic [2:0]          cfg_idx;

    // effective geometry
    logic [DIM_W-1:0]    w_eff, h_eff, bar_h;
    logic [ACROSS_W-1:0] a_eff;
    logic [DOWN_W-1:0]   d_eff;
    logic [DIM_W-1:0]    side_w_reg, side_h_reg, band_w_reg, band_h_reg, band_h2_reg;
    logic [DIM_W-1:0]    right_start_reg, lower_start_reg, bp_start_reg;
    logic [DIM_W-1:0]    ts_end_reg, bs_start_reg;
    logic [SUM_W-1:0]    limit_reg;
    logic [DIVS_W-1:0]   side_n_reg, bn_plain_reg, bn_shift_reg, band_n_reg;
    logic [2:0]          geom_step_reg;

    // raster position
    logic [CNT_W-1:0]    col_reg, row_reg;
    logic [ACROSS_W-1:0] czone_reg;
    logic [DIM_W-1:0]    coff_reg, roff_reg;
    logic [DOWN_W-1:0]   rzone_reg;
    logic [SUM_W-1:0]    upper_reg, lower_reg;

    // pixel in flight
    logic [2:0][7:0]     pix_reg;
    logic                f_left_reg, f_right_reg, f_tp_reg, f_ts_reg, f_bp_reg, f_bs_reg;
    logic [BAND_AW-1:0]  pix_baddr_reg;
    logic [SIDE_AW-1:0]  pix_saddr_reg;
    logic                pix_last_reg;

    // frame end
    logic                shifted_reg, side_phase_reg;
    logic [ACROSS_W-1:0] fidx_reg;
    logic [2:0]          dch_reg;
    logic [5:0][SUM_W-1:0] hold_reg;
    logic [COLOR_W-1:0]  color_a_reg, color_b_reg;
    logic [BAND_AW-1:0]  clr_reg;

    state_t state_reg, state_next;

    // memories
    band_entry_t band_mem [MAX_LEDS_ACROSS];
    side_entry_t side_mem [MAX_LEDS_DOWN];
    band_entry_t band_rdata_reg, band_wdata;
    side_entry_t side_rdata_reg, side_wdata;
    logic               band_re, band_we, side_re, side_we;
    logic [BAND_AW-1:0] band_raddr, band_waddr;
    logic [SIDE_AW-1:0] side_raddr, side_waddr;

    // divider and led store
    logic               div_start, div_done;
    logic [SUM_W-1:0]   div_dividend, div_quotient;
    logic [DIVS_W-1:0]  div_divisor;
    logic [7:0]         mean_byte;
    led_wr_t            led_wr;
    logic               led_rd_en;
    logic [COLOR_W-1:0] led_rd_data;

    // output register
    logic               out_valid_reg, out_load;
    logic [COLOR_W-1:0] led_color_reg;

    // pixel flags and counter steps
    logic [DIM_W-1:0]   x13, y13;
    logic               side_ok, band_ok;
    logic               f_up, f_lo, f_left, f_right, f_tp, f_ts, f_bp, f_bs;
    logic               x_last, y_last;
    logic [SUM_W-1:0]   pix_total;
    logic [LED_AW-1:0]  d8, a8, i8, addr_a, addr_b;

    function automatic rgb_sum_t add_rgb(rgb_sum_t s, logic en, logic [2:0][7:0] px);
        rgb_sum_t r;
        for (int c = 0; c < 3; c++)
            r[c] = s[c] + (en ? SUM_W'(px[c]) : '0);
        return r;
    endfunction

    assign cfg_idx = paddr[4:2];
    assign cfg_hit = psel && penable && pwrite && (cfg_idx <= REG_BAR_DETECT);
    assign pready  = 1'b1;

    always_comb
    begin
        unique case (cfg_idx)
            REG_FRAME_WIDTH:  prdata = PDATA_W'(fw_reg);
            REG_FRAME_HEIGHT: prdata = PDATA_W'(fh_reg);
            REG_LEDS_ACROSS:  prdata = PDATA_W'(la_reg);
            REG_LEDS_DOWN:    prdata = PDATA_W'(ld_reg);
            REG_BOTTOM_EN:    prdata = PDATA_W'(be_reg);
            REG_BAR_DETECT:   prdata = PDATA_W'(bd_reg);
            default:          prdata = '0;
        endcase
    end

    assign w_eff = (fw_reg == '0) ? DIM_W'(1) :
                   ((32'(fw_reg) > MAX_FRAME_DIM) ? DIM_W'(MAX_FRAME_DIM) : fw_reg);
    assign h_eff = (fh_reg == '0) ? DIM_W'(1) :
                   ((32'(fh_reg) > MAX_FRAME_DIM) ? DIM_W'(MAX_FRAME_DIM) : fh_reg);
    assign a_eff = (la_reg == '0) ? ACROSS_W'(1) :
                   ((32'(la_reg) > MAX_LEDS_ACROSS) ? ACROSS_W'(MAX_LEDS_ACROSS) : la_reg);
    assign d_eff = (ld_reg == '0) ? DOWN_W'(1) :
                   ((32'(ld_reg) > MAX_LEDS_DOWN) ? DOWN_W'(MAX_LEDS_DOWN) : ld_reg);
    assign bar_h = h_eff >> 3;

    // zone membership of the pixel at the current raster position
    assign x13     = DIM_W'(col_reg);
    assign y13     = DIM_W'(row_reg);
    assign f_up    = y13 < bar_h;
    assign f_lo    = (bar_h != '0) && (y13 >= lower_start_reg);
    assign side_ok = (side_h_reg != '0) && (rzone_reg < d_eff);
    assign f_left  = side_ok && (x13 < side_w_reg);
    assign f_right = side_ok && (side_w_reg != '0) && (x13 >= right_start_reg);
    assign band_ok = (band_w_reg != '0) && (czone_reg < a_eff);
    assign f_tp    = band_ok && (y13 < band_h_reg);
    assign f_bp    = band_ok && (y13 >= bp_start_reg);
    assign f_ts    = band_ok && (y13 >= bar_h) && (y13 < ts_end_reg);
    assign f_bs    = band_ok && (y13 >= bs_start_reg) && (y13 < lower_start_reg);
    assign x_last  = (x13 + DIM_W'(1)) >= w_eff;
    assign y_last  = (y13 + DIM_W'(1)) >= h_eff;
    assign pix_total = SUM_W'(red) + SUM_W'(green) + SUM_W'(blue);

    // ring positions of the led pair being produced
    assign d8 = LED_AW'(d_eff);
    assign a8 = LED_AW'(a_eff);
    assign i8 = LED_AW'(fidx_reg);
    assign addr_a = side_phase_reg ? (d8 - LED_AW'(1) - i8) : (d8 + i8);
    assign addr_b = side_phase_reg ? (d8 + a8 + i8) :
                    ((d8 << 1) + (a8 << 1) - LED_AW'(1) - i8);

    // divider operands
    always_comb
    begin
        div_dividend = hold_reg[dch_reg];
        div_divisor  = side_phase_reg ? side_n_reg : band_n_reg;
        if (state_reg == ST_GEOM_DIV)
        begin
            unique case (geom_step_reg)
                GS_SIDE_W:
                begin
                    div_dividend = SUM_W'(w_eff) * SUM_W'(3);
                    div_divisor  = DIVS_W'(10);
                end
                GS_SIDE_H:
                begin
                    div_dividend = SUM_W'(h_eff);
                    div_divisor  = DIVS_W'(d_eff);
                end
                GS_BAND_W:
                begin
                    div_dividend = SUM_W'(w_eff);
                    div_divisor  = DIVS_W'(a_eff);
                end
                GS_BAND_H:
                begin
                    div_dividend = SUM_W'(h_eff);
                    div_divisor  = DIVS_W'(5);
                end
                default:
                begin
                    div_dividend = SUM_W'(h_eff - (bar_h << 1));
                    div_divisor  = DIVS_W'(5);
                end
            endcase
        end
    end

    // empty zone gives zero
    assign mean_byte = (div_divisor == '0) ? 8'd0 : div_quotient[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_GEOM_DIV;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        in_stall   = 1'b1;
        div_start  = 1'b0;
        led_rd_en  = 1'b0;
        led_wr     = '0;
        out_load   = 1'b0;
        band_re    = 1'b0;
        side_re    = 1'b0;
        band_we    = 1'b0;
        side_we    = 1'b0;
        band_raddr = czone_reg[BAND_AW-1:0];
        side_raddr = rzone_reg[SIDE_AW-1:0];
        band_waddr = fidx_reg[BAND_AW-1:0];
        side_waddr = fidx_reg[SIDE_AW-1:0];
        band_wdata = '0;
        side_wdata = '0;
        unique case (state_reg)
            ST_GEOM_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_GEOM_WAIT;
            end
            ST_GEOM_WAIT:
            begin
                if (div_done)
                    state_next = (geom_step_reg == GS_BAND_H2) ? ST_GEOM_MUL : ST_GEOM_DIV;
            end
            ST_GEOM_MUL:
                state_next = ST_CLEAR;
            ST_CLEAR:
            begin
                band_we    = 1'b1;
                side_we    = 1'b1;
                band_waddr = clr_reg;
                side_waddr = clr_reg[SIDE_AW-1:0];
                if (clr_reg == '1)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = cfg_hit;
                if (in_valid && !cfg_hit)
                begin
                    if (operation)
                    begin
                        led_rd_en  = 1'b1;
                        state_next = ST_READ;
                    end
                    else
                    begin
                        band_re    = 1'b1;
                        side_re    = 1'b1;
                        state_next = ST_PIX_WR;
                    end
                end
            end
            ST_PIX_WR:
            begin
                band_we       = f_tp_reg || f_ts_reg || f_bp_reg || f_bs_reg;
                side_we       = f_left_reg || f_right_reg;
                band_waddr    = pix_baddr_reg;
                side_waddr    = pix_saddr_reg;
                band_wdata.tp = add_rgb(band_rdata_reg.tp, f_tp_reg, pix_reg);
                band_wdata.ts = add_rgb(band_rdata_reg.ts, f_ts_reg, pix_reg);
                band_wdata.bp = add_rgb(band_rdata_reg.bp, f_bp_reg, pix_reg);
                band_wdata.bs = add_rgb(band_rdata_reg.bs, f_bs_reg, pix_reg);
                side_wdata.left  = add_rgb(side_rdata_reg.left, f_left_reg, pix_reg);
                side_wdata.right = add_rgb(side_rdata_reg.right, f_right_reg, pix_reg);
                state_next    = pix_last_reg ? ST_FIN_START : ST_IDLE;
            end
            ST_READ:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_FIN_START:
                state_next = ST_FIN_RD;
            ST_FIN_RD:
            begin
                band_raddr = fidx_reg[BAND_AW-1:0];
                side_raddr = fidx_reg[SIDE_AW-1:0];
                if (side_phase_reg)
                begin
                    if (fidx_reg < ACROSS_W'(d_eff))
                    begin
                        side_re    = 1'b1;
                        state_next = ST_FIN_LATCH;
                    end
                end
                else if (fidx_reg < a_eff)
                begin
                    band_re    = 1'b1;
                    state_next = ST_FIN_LATCH;
                end
                else
                    state_next = ST_IDLE;
            end
            ST_FIN_LATCH:
            begin
                // the entry is read out, clear it for the next frame
                side_we    = side_phase_reg;
                band_we    = !side_phase_reg;
                state_next = ST_FIN_DIV;
            end
            ST_FIN_DIV:
            begin
                div_start  = 1'b1;
                state_next = ST_FIN_WAIT;
            end
            ST_FIN_WAIT:
            begin
                if (div_done)
                    state_next = (dch_reg == 3'd5) ? ST_FIN_WR_A : ST_FIN_DIV;
            end
            ST_FIN_WR_A:
            begin
                led_wr     = '{en: 1'b1, addr: addr_a, data: color_a_reg};
                state_next = ST_FIN_WR_B;
            end
            ST_FIN_WR_B:
            begin
                led_wr     = '{en: side_phase_reg || be_reg, addr: addr_b, data: color_b_reg};
                state_next = ST_FIN_RD;
            end
            default:
                state_next = ST_IDLE;
        endcase
        if (cfg_hit)
            state_next = ST_GEOM_DIV;
    end

    // configuration, counters and sequencing registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fw_reg         <= DIM_W'(1920);
            fh_reg         <= DIM_W'(1080);
            la_reg         <= ACROSS_W'(50);
            ld_reg         <= DOWN_W'(20);
            be_reg         <= 1'b1;
            bd_reg         <= 1'b1;
            geom_step_reg  <= GS_SIDE_W;
            col_reg        <= '0;
            row_reg        <= '0;
            czone_reg      <= '0;
            coff_reg       <= '0;
            rzone_reg      <= '0;
            roff_reg       <= '0;
            upper_reg      <= '0;
            lower_reg      <= '0;
            pix_last_reg   <= 1'b0;
            clr_reg        <= '0;
            fidx_reg       <= '0;
            dch_reg        <= '0;
            side_phase_reg <= 1'b1;
            shifted_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (out_valid_reg && !out_stall)
                out_valid_reg <= 1'b0;

            if (cfg_hit)
            begin
                unique case (cfg_idx)
                    REG_FRAME_WIDTH:  fw_reg <= pwdata[DIM_W-1:0];
                    REG_FRAME_HEIGHT: fh_reg <= pwdata[DIM_W-1:0];
                    REG_LEDS_ACROSS:  la_reg <= pwdata[ACROSS_W-1:0];
                    REG_LEDS_DOWN:    ld_reg <= pwdata[DOWN_W-1:0];
                    REG_BOTTOM_EN:    be_reg <= pwdata[0];
                    default:          bd_reg <= pwdata[0];
                endcase
                geom_step_reg <= GS_SIDE_W;
                clr_reg       <= '0;
                col_reg       <= '0;
                row_reg       <= '0;
                czone_reg     <= '0;
                coff_reg      <= '0;
                rzone_reg     <= '0;
                roff_reg      <= '0;
                upper_reg     <= '0;
                lower_reg     <= '0;
            end
            else
            begin
                unique case (state_reg)
                    ST_GEOM_WAIT:
                        if (div_done)
                            geom_step_reg <= geom_step_reg + 3'd1;
                    ST_GEOM_MUL:
                        geom_step_reg <= GS_SIDE_W;
                    ST_CLEAR:
                        clr_reg <= clr_reg + BAND_AW'(1);
                    ST_IDLE:
                    begin
                        if (in_valid && !operation)
                        begin
                            if (f_up)
                                upper_reg <= upper_reg + pix_total;
                            if (f_lo)
                                lower_reg <= lower_reg + pix_total;
                            pix_last_reg <= x_last && y_last;
                            if (x_last)
                            begin
                                col_reg   <= '0;
                                czone_reg <= '0;
                                coff_reg  <= '0;
                                if (y_last)
                                begin
                                    row_reg   <= '0;
                                    rzone_reg <= '0;
                                    roff_reg  <= '0;
                                end
                                else
                                begin
                                    row_reg <= row_reg + CNT_W'(1);
                                    if ((roff_reg + DIM_W'(1)) >= side_h_reg)
                                    begin
                                        roff_reg <= '0;
                                        if (rzone_reg < d_eff)
                                            rzone_reg <= rzone_reg + DOWN_W'(1);
                                    end
                                    else
                                        roff_reg <= roff_reg + DIM_W'(1);
                                end
                            end
                            else
                            begin
                                col_reg <= col_reg + CNT_W'(1);
                                if ((coff_reg + DIM_W'(1)) >= band_w_reg)
                                begin
                                    coff_reg <= '0;
                                    if (czone_reg < a_eff)
                                        czone_reg <= czone_reg + ACROSS_W'(1);
                                end
                                else
                                    coff_reg <= coff_reg + DIM_W'(1);
                            end
                        end
                    end
                    ST_FIN_START:
                    begin
                        shifted_reg    <= bd_reg && (bar_h != '0) &&
                                          (upper_reg < limit_reg) && (lower_reg < limit_reg);
                        upper_reg      <= '0;
                        lower_reg      <= '0;
                        fidx_reg       <= '0;
                        side_phase_reg <= 1'b1;
                    end
                    ST_FIN_RD:
                    begin
                        if (side_phase_reg && (fidx_reg >= ACROSS_W'(d_eff)))
                        begin
                            side_phase_reg <= 1'b0;
                            fidx_reg       <= '0;
                        end
                    end
                    ST_FIN_LATCH:
                        dch_reg <= '0;
                    ST_FIN_WAIT:
                        if (div_done)
                            dch_reg <= dch_reg + 3'd1;
                    ST_FIN_WR_B:
                        fidx_reg <= fidx_reg + ACROSS_W'(1);
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // geometry and datapath payload
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_GEOM_WAIT && div_done)
        begin
            unique case (geom_step_reg)
                GS_SIDE_W:  side_w_reg  <= div_quotient[DIM_W-1:0];
                GS_SIDE_H:  side_h_reg  <= div_quotient[DIM_W-1:0];
                GS_BAND_W:  band_w_reg  <= div_quotient[DIM_W-1:0];
                GS_BAND_H:  band_h_reg  <= div_quotient[DIM_W-1:0];
                default:    band_h2_reg <= div_quotient[DIM_W-1:0];
            endcase
        end
        if (state_reg == ST_GEOM_MUL)
        begin
            limit_reg       <= SUM_W'(bar_h) * SUM_W'(w_eff) * SUM_W'(18);
            side_n_reg      <= DIVS_W'(side_w_reg) * DIVS_W'(side_h_reg);
            bn_plain_reg    <= DIVS_W'(band_w_reg) * DIVS_W'(band_h_reg);
            bn_shift_reg    <= DIVS_W'(band_w_reg) * DIVS_W'(band_h2_reg);
            right_start_reg <= w_eff - side_w_reg;
            lower_start_reg <= h_eff - bar_h;
            bp_start_reg    <= h_eff - band_h_reg;
            ts_end_reg      <= bar_h + band_h2_reg;
            bs_start_reg    <= h_eff - band_h2_reg - bar_h;
        end
        if (state_reg == ST_IDLE)
        begin
            pix_reg       <= {blue, green, red};
            f_left_reg    <= f_left;
            f_right_reg   <= f_right;
            f_tp_reg      <= f_tp;
            f_ts_reg      <= f_ts;
            f_bp_reg      <= f_bp;
            f_bs_reg      <= f_bs;
            pix_baddr_reg <= czone_reg[BAND_AW-1:0];
            pix_saddr_reg <= rzone_reg[SIDE_AW-1:0];
        end
        if (state_reg == ST_FIN_START)
            band_n_reg <= (bd_reg && (bar_h != '0) && (upper_reg < limit_reg) &&
                           (lower_reg < limit_reg)) ? bn_shift_reg : bn_plain_reg;
        if (state_reg == ST_FIN_LATCH)
        begin
            if (side_phase_reg)
                hold_reg <= {side_rdata_reg.right, side_rdata_reg.left};
            else if (shifted_reg)
                hold_reg <= {band_rdata_reg.bs, band_rdata_reg.ts};
            else
                hold_reg <= {band_rdata_reg.bp, band_rdata_reg.tp};
        end
        if (state_reg == ST_FIN_WAIT && div_done)
        begin
            if (dch_reg < 3'd3)
                color_a_reg <= {color_a_reg[COLOR_W-9:0], mean_byte};
            else
                color_b_reg <= {color_b_reg[COLOR_W-9:0], mean_byte};
        end
        if (out_load)
            led_color_reg <= led_rd_data;
    end

    // zone sum memories
    always_ff @(posedge clk)
    begin
        if (band_we)
            band_mem[band_waddr] <= band_wdata;
        if (band_re)
            band_rdata_reg <= band_mem[band_raddr];
        if (side_we)
            side_mem[side_waddr] <= side_wdata;
        if (side_re)
            side_rdata_reg <= side_mem[side_raddr];
    end

    edza_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quotient)
    );

    edza_led u_led (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr      (led_wr),
        .rd_en   (led_rd_en),
        .rd_addr (led_index),
        .rd_data (led_rd_data)
    );

    assign out_valid = out_valid_reg;
    assign led_color = led_color_reg;

    // a pixel transaction always goes to its write-back cycle
    a_pix_wb: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && !operation) |=> (state_reg == ST_PIX_WR || $past(cfg_hit)))
        else $error("pixel transaction without write-back");

    // raster position stays inside the frame between transactions
    a_pos: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE) |-> (x13 < w_eff && y13 < h_eff))
        else $error("raster position outside frame");

    // frame-end writes land inside the ring
    a_led_addr: assert property (@(posedge clk) disable iff (!rst_n)
        led_wr.en |-> (32'(led_wr.addr) < 2 * 32'(a_eff) + 2 * 32'(d_eff)))
        else $error("led write outside ring");

    // a result appears only after a read transaction
    a_out_src: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> ($past(state_reg) == ST_READ))
        else $error("result without read transaction");

endmodule
